// ===== design/quaternion_pose_to_euler_frame_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion pose block
// Concurrent checks that are compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_POSE_TO_EULER_FRAME_DEFINES_SVH
`define QUATERNION_POSE_TO_EULER_FRAME_DEFINES_SVH

`ifndef SYNTH
// Check that is skipped while reset is high.
`define QPE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("qpe check failed");
// Check that also holds during reset.
`define QPE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("qpe reset check failed");
`else
`define QPE_ASSERT(lbl, prop)
`define QPE_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== design/qpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion pose package
// Types, pipeline lengths and the arctangent table shared by the block.
// ----------------------------------------------------------------------------
package qpe_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int CW            = 36;
  localparam int SQRT_STEPS    = 29;

  localparam int LAT_FRONT  = 2;
  localparam int LAT_ROT    = 3;
  localparam int LAT_SQRT   = 2 + SQRT_STEPS;
  localparam int LAT_CORDIC = CORDIC_N + 1;
  localparam int ANG_DLY    = LAT_SQRT;
  localparam int ROT_DLY    = LAT_SQRT + LAT_CORDIC - LAT_ROT;
  localparam int LAT_TOTAL  = LAT_FRONT + LAT_SQRT + LAT_CORDIC + 1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               pitch_clamped;
    logic               pos_saturated;
  } result_t;

  typedef struct packed {
    logic signed [30:0] m00;
    logic signed [30:0] m01;
    logic signed [30:0] m02;
    logic signed [30:0] m10;
    logic signed [30:0] m11;
    logic signed [30:0] m12;
    logic signed [30:0] m20;
    logic signed [30:0] m21;
    logic signed [30:0] m22;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [29:0] s;
    logic               pclamp;
    logic signed [CW-1:0] roll_x;
    logic signed [CW-1:0] roll_y;
    logic signed [CW-1:0] yaw_x;
    logic signed [CW-1:0] yaw_y;
  } front_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               sat;
    logic               pclamp;
  } rot_t;

  // atan(2^-i) as a 32-bit binary angle, 2^31 = pi.
  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== design/qpe_front.sv =====
// ----------------------------------------------------------------------------
// Quaternion front end
// Two stages: component products, then matrix entries and angle arguments.
// ----------------------------------------------------------------------------
module qpe_front (
  input  logic            clk,
  input  qpe_pkg::pose_t  pose,
  output qpe_pkg::front_t f
);

  logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [31:0] px, py, pz;
  logic signed [33:0] r00, r01, r02, r10, r11, r12, r20, r21, r22, s_raw;
  logic signed [33:0] roll_y, yaw_y;
  logic               s_hi, s_lo;

  function automatic logic signed [30:0] clamp2(input logic signed [33:0] v);
    logic signed [30:0] r;
    if (v > 34'sd536870912) begin
      r = 31'sd536870912;
    end else if (v < -34'sd536870912) begin
      r = -31'sd536870912;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    xx <= 32'(pose.quat_x * pose.quat_x);
    yy <= 32'(pose.quat_y * pose.quat_y);
    zz <= 32'(pose.quat_z * pose.quat_z);
    xy <= 32'(pose.quat_x * pose.quat_y);
    xz <= 32'(pose.quat_x * pose.quat_z);
    yz <= 32'(pose.quat_y * pose.quat_z);
    wx <= 32'(pose.quat_w * pose.quat_x);
    wy <= 32'(pose.quat_w * pose.quat_y);
    wz <= 32'(pose.quat_w * pose.quat_z);
    px <= pose.pos_x;
    py <= pose.pos_y;
    pz <= pose.pos_z;
  end

  always_comb begin
    r00 = 34'sd268435456 - ((34'(yy) + 34'(zz)) <<< 1);
    r11 = 34'sd268435456 - ((34'(xx) + 34'(zz)) <<< 1);
    r22 = 34'sd268435456 - ((34'(xx) + 34'(yy)) <<< 1);
    r01 = (34'(xy) - 34'(wz)) <<< 1;
    r02 = (34'(xz) + 34'(wy)) <<< 1;
    r10 = (34'(xy) + 34'(wz)) <<< 1;
    r12 = (34'(yz) - 34'(wx)) <<< 1;
    r20 = (34'(xz) - 34'(wy)) <<< 1;
    r21 = (34'(yz) + 34'(wx)) <<< 1;
    s_raw  = (34'(wy) - 34'(xz)) <<< 1;
    roll_y = (34'(wx) + 34'(yz)) <<< 1;
    yaw_y  = (34'(wz) + 34'(xy)) <<< 1;
    s_hi = s_raw > 34'sd268435456;
    s_lo = s_raw < -34'sd268435456;
  end

  always_ff @(posedge clk) begin
    f.m00 <= clamp2(r00);
    f.m01 <= clamp2(r01);
    f.m02 <= clamp2(r02);
    f.m10 <= clamp2(r10);
    f.m11 <= clamp2(r11);
    f.m12 <= clamp2(r12);
    f.m20 <= clamp2(r20);
    f.m21 <= clamp2(r21);
    f.m22 <= clamp2(r22);
    f.px  <= px;
    f.py  <= py;
    f.pz  <= pz;
    if (s_hi) begin
      f.s <= 30'sd268435456;
    end else if (s_lo) begin
      f.s <= -30'sd268435456;
    end else begin
      f.s <= s_raw[29:0];
    end
    f.pclamp <= s_hi | s_lo;
    f.roll_x <= qpe_pkg::CW'(r22);
    f.roll_y <= qpe_pkg::CW'(roll_y);
    f.yaw_x  <= qpe_pkg::CW'(r00);
    f.yaw_y  <= qpe_pkg::CW'(yaw_y);
  end

endmodule

// ===== design/qpe_rotate.sv =====
// ----------------------------------------------------------------------------
// Position rotation
// Transposed matrix times position: products, rounded sums, saturation.
// ----------------------------------------------------------------------------
module qpe_rotate (
  input  logic            clk,
  input  qpe_pkg::front_t f,
  output qpe_pkg::rot_t   r
);

  logic signed [62:0] p00, p10, p20, p01, p11, p21, p02, p12, p22;
  logic               pc3, pc4;
  logic signed [64:0] ax, ay, az;
  logic signed [36:0] vx, vy, vz;
  logic               sx, sy, sz;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] o;
    if (v > 37'sd2147483647) begin
      o = 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      o = 32'sh80000000;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

  function automatic logic ovf32(input logic signed [36:0] v);
    return (v > 37'sd2147483647) || (v < -37'sd2147483648);
  endfunction

  always_ff @(posedge clk) begin
    p00 <= 63'(f.m00) * 63'(f.px);
    p10 <= 63'(f.m10) * 63'(f.py);
    p20 <= 63'(f.m20) * 63'(f.pz);
    p01 <= 63'(f.m01) * 63'(f.px);
    p11 <= 63'(f.m11) * 63'(f.py);
    p21 <= 63'(f.m21) * 63'(f.pz);
    p02 <= 63'(f.m02) * 63'(f.px);
    p12 <= 63'(f.m12) * 63'(f.py);
    p22 <= 63'(f.m22) * 63'(f.pz);
    pc3 <= f.pclamp;
  end

  always_comb begin
    ax = 65'(p00) + 65'(p10) + 65'(p20) + 65'sd134217728;
    ay = 65'(p01) + 65'(p11) + 65'(p21) + 65'sd134217728;
    az = 65'(p02) + 65'(p12) + 65'(p22) + 65'sd134217728;
  end

  always_ff @(posedge clk) begin
    vx  <= 37'(ax >>> 28);
    vy  <= 37'(ay >>> 28);
    vz  <= 37'(az >>> 28);
    pc4 <= pc3;
  end

  always_comb begin
    sx = ovf32(vx);
    sy = ovf32(vy);
    sz = ovf32(vz);
  end

  always_ff @(posedge clk) begin
    r.rot_x  <= sat32(vx);
    r.rot_y  <= sat32(vy);
    r.rot_z  <= sat32(vz);
    r.sat    <= sx | sy | sz;
    r.pclamp <= pc4;
  end

endmodule

// ===== design/qpe_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pitch cosine term
// Computes floor(sqrt(2^56 - s^2)), one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module qpe_sqrt (
  input  logic               clk,
  input  logic signed [29:0] s_in,
  output logic        [28:0] c,
  output logic signed [29:0] s_out
);

  localparam int N = qpe_pkg::SQRT_STEPS;

  logic        [57:0] ss;
  logic signed [29:0] s3;
  logic        [57:0] rem [0:N];
  logic        [57:0] res [0:N];
  logic signed [29:0] sp  [0:N];

  always_ff @(posedge clk) begin
    ss     <= 58'(s_in * s_in);
    s3     <= s_in;
    rem[0] <= (58'd1 << 56) - ss;
    res[0] <= '0;
    sp[0]  <= s3;
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [57:0] bitv, trial;
    assign bitv  = 58'd1 << (56 - 2 * k);
    assign trial = res[k] + bitv;
    always_ff @(posedge clk) begin
      if (rem[k] >= trial) begin
        rem[k+1] <= rem[k] - trial;
        res[k+1] <= (res[k] >> 1) + bitv;
      end else begin
        rem[k+1] <= rem[k];
        res[k+1] <= res[k] >> 1;
      end
      sp[k+1] <= sp[k];
    end
  end

  assign c     = res[N][28:0];
  assign s_out = sp[N];

endmodule

// ===== design/qpe_cordic.sv =====
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// Pipelined atan2 giving a 32-bit binary angle, one stage per iteration.
// ----------------------------------------------------------------------------
module qpe_cordic (
  input  logic                          clk,
  input  logic signed [qpe_pkg::CW-1:0] x_in,
  input  logic signed [qpe_pkg::CW-1:0] y_in,
  output logic        [31:0]            z_out
);

  localparam int N = qpe_pkg::CORDIC_N;

  logic signed [qpe_pkg::CW-1:0] xs [0:N];
  logic signed [qpe_pkg::CW-1:0] ys [0:N];
  logic        [31:0]            zs [0:N];
  logic                          zf [0:N];

  // Left half plane is folded over by a half turn first.
  always_ff @(posedge clk) begin
    zf[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      xs[0] <= -x_in;
      ys[0] <= -y_in;
      zs[0] <= 32'h80000000;
    end else begin
      xs[0] <= x_in;
      ys[0] <= y_in;
      zs[0] <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    always_ff @(posedge clk) begin
      zf[k+1] <= zf[k];
      if (ys[k] >= 0) begin
        xs[k+1] <= xs[k] + (ys[k] >>> k);
        ys[k+1] <= ys[k] - (xs[k] >>> k);
        zs[k+1] <= zs[k] + qpe_pkg::atan_entry(k);
      end else begin
        xs[k+1] <= xs[k] - (ys[k] >>> k);
        ys[k+1] <= ys[k] + (xs[k] >>> k);
        zs[k+1] <= zs[k] - qpe_pkg::atan_entry(k);
      end
    end
  end

  assign z_out = zf[N] ? 32'd0 : zs[N];

endmodule

// ===== design/quaternion_pose_to_euler_frame.sv =====
// ----------------------------------------------------------------------------
// Quaternion pose to marker frame and Euler angles
// Rotates a position by the conjugate quaternion and derives roll/pitch/yaw.
// ----------------------------------------------------------------------------
// A pose is transferred when start is high and busy is low; busy is only high
// during reset and the cycle after it, so a new pose may be started in every
// cycle. Each pose gives exactly one result, shown on result for one cycle with
// done high. The delay from transfer to result is set by the pitch path: two
// front-end stages, a square root of 31 stages (a squaring stage, a subtract
// stage and 29 stages that each produce one result bit), the CORDIC with one
// stage per iteration plus a half-turn fold, and the output register. The
// receiver cannot hold results off, so results must be taken as they appear.
`include "quaternion_pose_to_euler_frame_defines.svh"

module quaternion_pose_to_euler_frame (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  qpe_pkg::pose_t   pose,
  output logic             done,
  output qpe_pkg::result_t result
);

  qpe_pkg::front_t f;
  qpe_pkg::rot_t   rot;
  logic        [28:0] c;
  logic signed [29:0] s_dly;
  logic        [31:0] roll_a, yaw_a, pitch_a;

  // The rotation result and the roll/yaw angles are ready well before pitch,
  // so they wait in delay lines until the pitch angle catches up.
  qpe_pkg::rot_t rot_dly  [0:qpe_pkg::ROT_DLY-1];
  logic [31:0]   roll_dly [0:qpe_pkg::ANG_DLY-1];
  logic [31:0]   yaw_dly  [0:qpe_pkg::ANG_DLY-1];
  logic          vpipe    [0:qpe_pkg::LAT_TOTAL-1];

  logic signed [32:0] pv_round;
  logic signed [16:0] pv_q;
  logic signed [15:0] pitch_sat;
  logic [31:0]        roll_r, yaw_r;

  qpe_front u_front (.clk(clk), .pose(pose), .f(f));
  qpe_rotate u_rot (.clk(clk), .f(f), .r(rot));
  qpe_sqrt u_sqrt (.clk(clk), .s_in(f.s), .c(c), .s_out(s_dly));

  qpe_cordic u_roll (.clk(clk), .x_in(f.roll_x), .y_in(f.roll_y), .z_out(roll_a));
  qpe_cordic u_yaw (.clk(clk), .x_in(f.yaw_x), .y_in(f.yaw_y), .z_out(yaw_a));
  qpe_cordic u_pitch (
    .clk(clk),
    .x_in(qpe_pkg::CW'({1'b0, c})),
    .y_in(qpe_pkg::CW'(s_dly)),
    .z_out(pitch_a)
  );

  always_ff @(posedge clk) begin
    rot_dly[0]  <= rot;
    roll_dly[0] <= roll_a;
    yaw_dly[0]  <= yaw_a;
    for (int i = 1; i < qpe_pkg::ROT_DLY; i++) begin
      rot_dly[i] <= rot_dly[i-1];
    end
    for (int i = 1; i < qpe_pkg::ANG_DLY; i++) begin
      roll_dly[i] <= roll_dly[i-1];
      yaw_dly[i]  <= yaw_dly[i-1];
    end
  end

  // Valid bits follow each pose down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      for (int i = 0; i < qpe_pkg::LAT_TOTAL; i++) begin
        vpipe[i] <= 1'b0;
      end
    end else begin
      busy     <= 1'b0;
      vpipe[0] <= start & ~busy;
      for (int i = 1; i < qpe_pkg::LAT_TOTAL; i++) begin
        vpipe[i] <= vpipe[i-1];
      end
    end
  end

  // Angles round half up to 16 bits; pitch is then limited to a quarter turn.
  always_comb begin
    pv_round = 33'(signed'(pitch_a)) + 33'sd32768;
    pv_q     = 17'(pv_round >>> 16);
    if (pv_q > 17'sd16384) begin
      pitch_sat = 16'sd16384;
    end else if (pv_q < -17'sd16384) begin
      pitch_sat = -16'sd16384;
    end else begin
      pitch_sat = pv_q[15:0];
    end
    roll_r = roll_dly[qpe_pkg::ANG_DLY-1] + 32'h00008000;
    yaw_r  = yaw_dly[qpe_pkg::ANG_DLY-1] + 32'h00008000;
  end

  always_ff @(posedge clk) begin
    result.rot_x         <= rot_dly[qpe_pkg::ROT_DLY-1].rot_x;
    result.rot_y         <= rot_dly[qpe_pkg::ROT_DLY-1].rot_y;
    result.rot_z         <= rot_dly[qpe_pkg::ROT_DLY-1].rot_z;
    result.pos_saturated <= rot_dly[qpe_pkg::ROT_DLY-1].sat;
    result.pitch_clamped <= rot_dly[qpe_pkg::ROT_DLY-1].pclamp;
    result.roll          <= roll_r[31:16];
    result.yaw           <= yaw_r[31:16];
    result.pitch         <= pitch_sat;
  end

  assign done = vpipe[qpe_pkg::LAT_TOTAL-1];

  // Every result traces back to a transfer exactly one latency earlier.
  `QPE_ASSERT(a_done_latency, done |-> $past(start && !busy, qpe_pkg::LAT_TOTAL))
  // Reset empties the pipeline and blocks new transfers.
  `QPE_ASSERT_RST(a_rst_clears, rst |=> (!done && busy))
  // Pitch never leaves the quarter-turn range.
  `QPE_ASSERT(a_pitch_range, done |-> (result.pitch <= 16'sd16384 && result.pitch >= -16'sd16384))
  // A saturation flag means at least one coordinate sits at a rail.
  `QPE_ASSERT(a_sat_rail, (done && result.pos_saturated) |-> (result.rot_x == 32'sh7fffffff || result.rot_x == 32'sh80000000 || result.rot_y == 32'sh7fffffff || result.rot_y == 32'sh80000000 || result.rot_z == 32'sh7fffffff || result.rot_z == 32'sh80000000))

endmodule
